// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the sorted-list RTL.
// Depends on clk_i and rst_ni being in scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property, ignored while reset is asserted.
`define SLI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Clocked property checked during reset as well.
`define SLI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SLI_ASSERT(lbl, prop, msg)
`define SLI_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: hw/rtl/sli_pkg.sv
// Shared types and constants for the sorted list block.
// No dependencies; used by sli_cell and sorted_list_insert_delete.
package sli_pkg;

  localparam int CAPACITY    = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int IDX_W       = $clog2(CAPACITY);

  localparam int IN_VALUE_W  = 32;
  localparam int ENTRY_W     = 32;
  localparam int COUNT_W     = 6;
  localparam int OUT_DATA_W  = ((ENTRY_W + COUNT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_DATA_W - ENTRY_W - COUNT_W;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_DUMP   = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_MISS  = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_EMPTY = 2'd3;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CMP,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPLY,
    ST_DUMP
  } state_e;

  typedef struct packed {
    cell_op_e op;
    logic     valid;    // cell lies inside the stored part of the list
    logic     left_le;  // left neighbor entry <= value (head: 1)
    logic     tail;     // cell holds the last stored entry
  } cell_ctl_t;

  typedef struct packed {
    logic le;
    logic lt;
    logic eq;
  } cell_flags_t;

endpackage

// File: hw/rtl/sli_cell.sv
// One storage cell of the sorted list: an entry plus its compare flags.
// Depends on sli_pkg.
module sli_cell (
  input  logic                 clk_i,
  input  sli_pkg::cell_ctl_t   ctl_i,
  input  sli_pkg::value_t      value_i,
  input  sli_pkg::value_t      left_entry_i,
  input  sli_pkg::value_t      right_entry_i,
  input  sli_pkg::value_t      head_entry_i,
  output sli_pkg::value_t      entry_o,
  output sli_pkg::cell_flags_t flags_o
);

  sli_pkg::value_t      entry_q, entry_d;
  sli_pkg::cell_flags_t flags_q, flags_d;

  always_comb begin
    entry_d = entry_q;
    flags_d = flags_q;
    case (ctl_i.op)
      sli_pkg::CELL_CMP: begin
        flags_d.le = ctl_i.valid && (entry_q <= value_i);
        flags_d.lt = ctl_i.valid && (entry_q < value_i);
        flags_d.eq = ctl_i.valid && (entry_q == value_i);
      end
      sli_pkg::CELL_INS: begin
        if (!flags_q.le) begin
          entry_d = ctl_i.left_le ? value_i : left_entry_i;
        end
      end
      sli_pkg::CELL_DEL: begin
        if (!flags_q.lt) begin
          entry_d = right_entry_i;
        end
      end
      sli_pkg::CELL_ROT: begin
        entry_d = ctl_i.tail ? head_entry_i : right_entry_i;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    flags_q <= flags_d;
  end

  assign entry_o = entry_q;
  assign flags_o = flags_q;

endmodule

// File: hw/rtl/sorted_list_insert_delete.sv
// Sorted list of signed values kept in a row of cells, with insert, delete and dump.
// Insert/delete: the item is accepted in IDLE, compared in CMP, and its result loaded in APPLY
// once the output is free; no new item is taken until this compare-then-shift pass is done.
// Dump: after the item is accepted, one entry per cycle while the output is not stalled.
// Reset (rst_ni low, asynchronous) empties the list and drops any pending result.
// Depends on sli_pkg, sli_cell and assert_macros.svh.
`include "assert_macros.svh"

module sorted_list_insert_delete (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input item
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [sli_pkg::IN_VALUE_W-1:0] s_axis_tdata_i,   // [31:0] value
  input  logic [1:0]                   s_axis_tuser_i,   // [1:0] action
  // result item
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [sli_pkg::OUT_DATA_W-1:0] m_axis_tdata_o, // [31:0] entry, [37:32] count
  output logic [1:0]                   m_axis_tuser_o,   // [1:0] status
  output logic                         m_axis_tlast_o    // last result of this item
);

  localparam int N = sli_pkg::CAPACITY;

  // Control state
  sli_pkg::state_e               state_q, state_d;
  logic [sli_pkg::CNT_W-1:0]     fill_q, fill_d;
  logic [sli_pkg::IDX_W-1:0]     dump_idx_q, dump_idx_d;
  logic                          out_valid_q, out_valid_d;

  // Payload registers
  logic [1:0]                    action_q;
  sli_pkg::value_t               value_q;
  logic signed [sli_pkg::ENTRY_W-1:0] out_entry_q, out_entry_d;
  logic [1:0]                    out_status_q, out_status_d;
  logic                          out_last_q, out_last_d;
  logic [sli_pkg::COUNT_W-1:0]   out_count_q, out_count_d;

  // Cell row
  sli_pkg::cell_op_e             cell_op;
  sli_pkg::cell_ctl_t            ctl   [N];
  sli_pkg::cell_flags_t          flags [N];
  sli_pkg::value_t               entry [N];
  logic [N-1:0]                  first_eq;

  logic in_acc;
  logic out_free;
  logic hit;
  logic full;
  logic dump_last;
  logic load;

  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign full      = (fill_q == sli_pkg::CNT_W'(N));
  assign dump_last = ((sli_pkg::CNT_W'(dump_idx_q) + sli_pkg::CNT_W'(1)) == fill_q);
  assign hit       = |first_eq;

  // Build the row: each cell sees its neighbors' entries and the left compare flag.
  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign ctl[i].left_le = 1'b1;
      assign first_eq[i]    = flags[i].eq;
    end else begin : g_body
      assign ctl[i].left_le = flags[i-1].le;
      assign first_eq[i]    = flags[i].eq && flags[i-1].lt;
    end
    assign ctl[i].op    = cell_op;
    assign ctl[i].valid = (sli_pkg::CNT_W'(i) < fill_q);
    assign ctl[i].tail  = ((sli_pkg::CNT_W'(i) + sli_pkg::CNT_W'(1)) == fill_q);

    sli_cell u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl[i]),
      .value_i       (value_q),
      .left_entry_i  (entry[(i == 0) ? 0 : i - 1]),
      .right_entry_i (entry[(i == N - 1) ? i : i + 1]),
      .head_entry_i  (entry[0]),
      .entry_o       (entry[i]),
      .flags_o       (flags[i])
    );
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sli_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser_i == sli_pkg::ACT_INSERT || s_axis_tuser_i == sli_pkg::ACT_DELETE) begin
            state_d = sli_pkg::ST_CMP;
          end else if (s_axis_tuser_i == sli_pkg::ACT_DUMP) begin
            state_d = sli_pkg::ST_DUMP;
          end
        end
      end
      sli_pkg::ST_CMP: begin
        state_d = sli_pkg::ST_APPLY;
      end
      sli_pkg::ST_APPLY: begin
        if (out_free) begin
          state_d = sli_pkg::ST_IDLE;
        end
      end
      sli_pkg::ST_DUMP: begin
        if (out_free && (fill_q == '0 || dump_last)) begin
          state_d = sli_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sli_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer: cell command, list length, dump index, result load
  always_comb begin
    cell_op      = sli_pkg::CELL_HOLD;
    fill_d       = fill_q;
    dump_idx_d   = dump_idx_q;
    load         = 1'b0;
    out_entry_d  = '0;
    out_status_d = sli_pkg::STAT_OK;
    out_last_d   = 1'b1;
    out_count_d  = sli_pkg::COUNT_W'(fill_q);
    case (state_q)
      sli_pkg::ST_IDLE: begin
        if (in_acc) begin
          dump_idx_d = '0;
        end
      end
      sli_pkg::ST_CMP: begin
        cell_op = sli_pkg::CELL_CMP;
      end
      sli_pkg::ST_APPLY: begin
        if (out_free) begin
          load = 1'b1;
          if (action_q == sli_pkg::ACT_INSERT) begin
            if (full) begin
              out_status_d = sli_pkg::STAT_FULL;
            end else begin
              cell_op     = sli_pkg::CELL_INS;
              fill_d      = fill_q + sli_pkg::CNT_W'(1);
              out_count_d = sli_pkg::COUNT_W'(fill_d);
            end
          end else if (hit) begin
            cell_op     = sli_pkg::CELL_DEL;
            fill_d      = fill_q - sli_pkg::CNT_W'(1);
            out_count_d = sli_pkg::COUNT_W'(fill_d);
          end else begin
            out_status_d = sli_pkg::STAT_MISS;
          end
        end
      end
      sli_pkg::ST_DUMP: begin
        if (out_free) begin
          load = 1'b1;
          if (fill_q == '0) begin
            out_status_d = sli_pkg::STAT_EMPTY;
          end else begin
            // Emit the head and rotate it to the tail; fill rotations restore the order.
            cell_op     = sli_pkg::CELL_ROT;
            out_entry_d = sli_pkg::ENTRY_W'(entry[0]);
            out_last_d  = dump_last;
            dump_idx_d  = dump_idx_q + sli_pkg::IDX_W'(1);
          end
        end
      end
      default: begin
        cell_op = sli_pkg::CELL_HOLD;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sli_pkg::ST_IDLE;
      fill_q      <= '0;
      dump_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      dump_idx_q  <= dump_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the accepted item and the pending result
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      action_q <= s_axis_tuser_i;
      value_q  <= sli_pkg::value_t'($signed(s_axis_tdata_i));
    end
    if (load) begin
      out_entry_q  <= out_entry_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
      out_count_q  <= out_count_d;
    end
  end

  assign s_axis_tready_o = (state_q == sli_pkg::ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{sli_pkg::OUT_PAD_W{1'b0}}, out_count_q, out_entry_q};
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

  `SLI_ASSERT(a_fill_bound, fill_q <= sli_pkg::CNT_W'(N), "fill exceeds capacity")
  `SLI_ASSERT(a_cmp_then_apply, state_q == sli_pkg::ST_CMP |=> state_q == sli_pkg::ST_APPLY,
              "compare not followed by apply")
  `SLI_ASSERT(a_single_match, state_q == sli_pkg::ST_APPLY |-> $onehot0(first_eq),
              "more than one first-equal cell")
  `SLI_ASSERT(a_apply_loads, state_q == sli_pkg::ST_APPLY && out_free |=> out_valid_q,
              "apply did not load a result")
  `SLI_ASSERT(a_dump_index, state_q == sli_pkg::ST_DUMP && fill_q != '0 |->
              sli_pkg::CNT_W'(dump_idx_q) < fill_q, "dump index past list end")

endmodule
